@@ src/mwee_pkg.sv @@
// Shared constants for the Microwire serial EEPROM device model.
package mwee_pkg;

  localparam int DataBits     = 8;
  localparam int DefStoreDepth = 256;
  localparam int CmdWidth     = 18;
  localparam int BusyWidth    = 20;
  localparam int AbitsWidth   = 4;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_CMD    = 3'd1;
  localparam logic [2:0] PH_WDATA  = 3'd2;
  localparam logic [2:0] PH_WFULL  = 3'd3;
  localparam logic [2:0] PH_READ   = 3'd4;
  localparam logic [2:0] PH_IGNORE = 3'd5;

  localparam logic [1:0] OP_EXT   = 2'b00;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_READ  = 2'b10;

  localparam logic [1:0] TOP_ENABLE  = 2'b11;
  localparam logic [1:0] TOP_DISABLE = 2'b00;

  localparam logic [2:0] REG_ABITS = 3'd0;
  localparam logic [2:0] REG_PCYC  = 3'd4;

  localparam logic [AbitsWidth-1:0] ABITS_RESET = 4'd8;
  localparam logic [AbitsWidth-1:0] ABITS_SHORT = 4'd7;
  localparam logic [BusyWidth-1:0]  PCYC_RESET  = 20'd5000;

endpackage

@@ src/microwire_eeprom_slave.sv @@
// Microwire x8 serial EEPROM device model with a pin-sample stream and an APB port.
//
// Channel   Dir  Beat contents
// s_axis    in   one sample of chip select, serial clock and data in
// m_axis    out  data out level, drive enable and busy flag for that sample
// apb       in   address_bits at 0x0, program_cycles at 0x4
//
// One sample is taken every cycle while s_tready is high, and its result appears in the next cycle.
// The byte store is a synchronous memory; a READ command fetches the byte at
// the sample that completes the address, and the fetched bit is shown at once.
// Reset clears all control state; every byte reads 0xFF until it is written.
// s_tready is low only while a finished result waits on a stalled m_tready.
module microwire_eeprom_slave #(
  parameter int STORE_DEPTH = mwee_pkg::DefStoreDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] chip_select, [1] serial_clock, [2] serial_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] serial_out, [1] out_driven, [2] busy_res
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mwee_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic [AbitsWidth-1:0] address_bits;
  logic [BusyWidth-1:0]  program_cycles;

  logic                  clock_prev;
  logic                  select_prev;
  logic [2:0]            phase;
  logic [3:0]            bit_count;
  logic [CmdWidth-1:0]   command_shift;
  logic [DataBits-1:0]   read_shift;
  logic                  read_from_mem;
  logic                  writes_enabled;
  logic                  show_status;
  logic [BusyWidth-1:0]  busy_count;

  logic [DataBits-1:0]   store [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] written;
  logic [DataBits-1:0]   mem_q;
  logic                  mem_ok;
  logic [DataBits-1:0]   mem_byte;

  logic out_valid, out_dout, out_drv, out_busy, out_use_mem;

  logic [2:0]            phase_next;
  logic [3:0]            bit_count_next;
  logic [CmdWidth-1:0]   command_shift_next;
  logic [DataBits-1:0]   read_shift_next;
  logic                  read_from_mem_next;
  logic                  writes_enabled_next;
  logic                  show_status_next;
  logic [BusyWidth-1:0]  busy_count_next;
  logic                  dout_next, drv_next, use_mem_next;

  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_idx, wr_idx;

  logic cs, sk, di, rise, fall, accept, short_addr;
  logic [3:0]            cmd_len, bc_inc;
  logic [CmdWidth-1:0]   shifted;
  logic [1:0]            op, top;
  logic [7:0]            rd_addr8, wr_addr8;
  logic [DataBits-1:0]   rs_cur;

  assign cs = s_tdata[0];
  assign sk = s_tdata[1];
  assign di = s_tdata[2];
  assign rise = sk & ~clock_prev;
  assign fall = ~sk & clock_prev;

  assign s_tready = ~out_valid | m_tready;
  assign accept = s_tvalid & s_tready;

  assign short_addr = (address_bits == ABITS_SHORT);
  assign cmd_len = short_addr ? 4'd9 : 4'd10;
  assign bc_inc = bit_count + 4'd1;
  assign shifted = {command_shift[CmdWidth-2:0], di};
  assign op = short_addr ? shifted[8:7] : shifted[9:8];
  assign rd_addr8 = short_addr ? {1'b0, shifted[6:0]} : shifted[7:0];
  assign top = short_addr ? shifted[6:5] : shifted[7:6];
  assign wr_addr8 = short_addr ? {1'b0, command_shift[14:8]} : command_shift[15:8];
  assign rd_idx = rd_addr8[AW-1:0];
  assign wr_idx = wr_addr8[AW-1:0];

  assign mem_byte = mem_ok ? mem_q : '1;
  assign rs_cur = read_from_mem ? mem_byte : read_shift;

  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    command_shift_next  = command_shift;
    read_shift_next     = rs_cur;
    read_from_mem_next  = 1'b0;
    writes_enabled_next = writes_enabled;
    show_status_next    = show_status;
    busy_count_next     = (busy_count != '0) ? busy_count - 1'b1 : busy_count;
    dout_next           = 1'b0;
    drv_next            = 1'b0;
    use_mem_next        = 1'b0;
    rd_en               = 1'b0;
    wr_en               = 1'b0;

    if (!cs) begin
      if (select_prev) begin
        if (phase == PH_WFULL && writes_enabled) begin
          wr_en            = 1'b1;
          busy_count_next  = program_cycles;
          show_status_next = 1'b1;
        end else begin
          show_status_next = 1'b0;
        end
      end
      phase_next     = PH_IDLE;
      bit_count_next = '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (rise && di && busy_count_next == '0) begin
            phase_next         = PH_CMD;
            bit_count_next     = '0;
            command_shift_next = '0;
            show_status_next   = 1'b0;
          end
        end
        PH_CMD: begin
          if (rise) begin
            command_shift_next = shifted;
            bit_count_next     = bc_inc;
            if (bc_inc >= cmd_len) begin
              bit_count_next = '0;
              unique case (op)
                OP_READ: begin
                  rd_en              = 1'b1;
                  read_from_mem_next = 1'b1;
                  phase_next         = PH_READ;
                end
                OP_WRITE: phase_next = PH_WDATA;
                OP_EXT: begin
                  if (top == TOP_ENABLE) begin
                    writes_enabled_next = 1'b1;
                  end else if (top == TOP_DISABLE) begin
                    writes_enabled_next = 1'b0;
                  end
                  phase_next = PH_IGNORE;
                end
                default: phase_next = PH_IGNORE;
              endcase
            end
          end
        end
        PH_WDATA: begin
          if (rise) begin
            command_shift_next = shifted;
            bit_count_next     = bc_inc;
            if (bc_inc >= 4'(DataBits)) begin
              phase_next = PH_WFULL;
            end
          end
        end
        PH_READ: begin
          read_from_mem_next = read_from_mem;
          if (fall) begin
            if (bit_count == '0) begin
              bit_count_next = 4'd1;
            end else begin
              read_shift_next    = {rs_cur[DataBits-2:0], 1'b0};
              read_from_mem_next = 1'b0;
            end
          end
        end
        default: ;
      endcase

      if (phase_next == PH_READ) begin
        drv_next     = 1'b1;
        use_mem_next = rd_en;
        dout_next    = read_shift_next[DataBits-1];
      end else if (phase_next == PH_IDLE && show_status_next) begin
        drv_next  = 1'b1;
        dout_next = (busy_count_next == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_prev     <= 1'b0;
      select_prev    <= 1'b0;
      phase          <= PH_IDLE;
      bit_count      <= '0;
      command_shift  <= '0;
      read_shift     <= '0;
      read_from_mem  <= 1'b0;
      writes_enabled <= 1'b0;
      show_status    <= 1'b0;
      busy_count     <= '0;
      written        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        clock_prev     <= sk;
        select_prev    <= cs;
        phase          <= phase_next;
        bit_count      <= bit_count_next;
        command_shift  <= command_shift_next;
        read_shift     <= read_shift_next;
        read_from_mem  <= read_from_mem_next;
        writes_enabled <= writes_enabled_next;
        show_status    <= show_status_next;
        busy_count     <= busy_count_next;
        if (wr_en) begin
          written[wr_idx] <= 1'b1;
        end
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_dout    <= dout_next;
      out_drv     <= drv_next;
      out_busy    <= (busy_count_next != '0);
      out_use_mem <= use_mem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      store[wr_idx] <= command_shift[DataBits-1:0];
    end
    if (accept && rd_en) begin
      mem_q  <= store[rd_idx];
      mem_ok <= written[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_bits   <= ABITS_RESET;
      program_cycles <= PCYC_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        program_cycles <= pwdata[BusyWidth-1:0];
      end else begin
        address_bits <= pwdata[AbitsWidth-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_PCYC) ? {{(32-BusyWidth){1'b0}}, program_cycles}
                : (paddr == REG_ABITS) ? {{(32-AbitsWidth){1'b0}}, address_bits}
                : '0;

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_busy, out_drv, out_use_mem ? mem_byte[DataBits-1] : out_dout};

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[1]) |-> !m_tdata[0])
    else $error("Data out is high while not driven.");

  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WFULL) |-> (bit_count == 4'(DataBits)))
    else $error("Write data phase ended with a wrong bit count.");

  assert property (@(posedge clk) disable iff (rst)
    (accept && !cs) |=> (phase == PH_IDLE && bit_count == '0))
    else $error("Deselect did not return the command logic to idle.");

  assert property (@(posedge clk) disable iff (rst)
    read_from_mem |-> (phase == PH_READ || !select_prev))
    else $error("Fetched byte is pending outside a read.");

endmodule
